// ===== sv/tovl_pkg.sv =====
// ----------------------------------------------------------------------------
// Text overlay package
// Shared types, register indexes, cell geometry and the 5x7 column font.
// ----------------------------------------------------------------------------
package tovl_pkg;

  localparam int LINE_CHARS_DEF = 128;

  // Cell geometry: 6 pixel pitch, first cell at column 3
  localparam int CELL_PITCH = 6;
  localparam int CELL_ORIGIN = 3;
  // n = (cx * CELL_RECIP) >> CELL_SHIFT is exact for every 12-bit cx
  localparam int CELL_RECIP = 43691;
  localparam int CELL_SHIFT = 18;

  localparam int DIM_ROWS = 10;
  localparam int GLYPH_TOP = 2;
  localparam int GLYPH_BOT = 8;

  localparam logic [31:0] DIM_MASK = 32'h00fe_fefe;
  localparam logic [31:0] ALPHA_MASK = 32'hff00_0000;
  localparam logic [31:0] INK_WHITE = 32'hffff_ffff;

  localparam logic [11:0] WIDTH_RST = 12'd256;
  localparam logic [11:0] HEIGHT_RST = 12'd224;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_PIXEL  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  // Pack five font columns, column 0 in the low byte
  function automatic logic [39:0] cols(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2, input logic [7:0] c3,
                                       input logic [7:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  // Dot of character ch at glyph column gx (0..4) and glyph row gy (0..6)
  function automatic logic dot_on(input logic [7:0] ch, input logic [2:0] gx,
                                  input logic [2:0] gy);
    logic [39:0] g;
    logic        has_g;
    logic [7:0]  col;
    logic        dot;
    g = '0;
    has_g = 1'b1;
    col = '0;
    dot = 1'b0;
    case (ch)
      8'h30: g = cols(8'd62, 8'd81, 8'd73, 8'd69, 8'd62);
      8'h31: g = cols(8'd0, 8'd66, 8'd127, 8'd64, 8'd0);
      8'h32: g = cols(8'd66, 8'd97, 8'd81, 8'd73, 8'd70);
      8'h33: g = cols(8'd33, 8'd65, 8'd69, 8'd75, 8'd49);
      8'h34: g = cols(8'd24, 8'd20, 8'd18, 8'd127, 8'd16);
      8'h35: g = cols(8'd39, 8'd69, 8'd69, 8'd69, 8'd57);
      8'h36: g = cols(8'd60, 8'd74, 8'd73, 8'd73, 8'd48);
      8'h37: g = cols(8'd1, 8'd113, 8'd9, 8'd5, 8'd3);
      8'h38: g = cols(8'd54, 8'd73, 8'd73, 8'd73, 8'd54);
      8'h39: g = cols(8'd6, 8'd73, 8'd73, 8'd41, 8'd30);
      8'h41: g = cols(8'd126, 8'd17, 8'd17, 8'd17, 8'd126);
      8'h42: g = cols(8'd127, 8'd73, 8'd73, 8'd73, 8'd54);
      8'h43: g = cols(8'd62, 8'd65, 8'd65, 8'd65, 8'd34);
      8'h44: g = cols(8'd127, 8'd65, 8'd65, 8'd34, 8'd28);
      8'h45: g = cols(8'd127, 8'd73, 8'd73, 8'd73, 8'd65);
      8'h46: g = cols(8'd127, 8'd9, 8'd9, 8'd9, 8'd1);
      8'h47: g = cols(8'd62, 8'd65, 8'd73, 8'd73, 8'd122);
      8'h48: g = cols(8'd127, 8'd8, 8'd8, 8'd8, 8'd127);
      8'h49: g = cols(8'd0, 8'd65, 8'd127, 8'd65, 8'd0);
      8'h4a: g = cols(8'd32, 8'd64, 8'd65, 8'd63, 8'd1);
      8'h4b: g = cols(8'd127, 8'd8, 8'd20, 8'd34, 8'd65);
      8'h4c: g = cols(8'd127, 8'd64, 8'd64, 8'd64, 8'd64);
      8'h4d: g = cols(8'd127, 8'd2, 8'd12, 8'd2, 8'd127);
      8'h4e: g = cols(8'd127, 8'd4, 8'd8, 8'd16, 8'd127);
      8'h4f: g = cols(8'd62, 8'd65, 8'd65, 8'd65, 8'd62);
      8'h50: g = cols(8'd127, 8'd9, 8'd9, 8'd9, 8'd6);
      8'h51: g = cols(8'd62, 8'd65, 8'd81, 8'd33, 8'd94);
      8'h52: g = cols(8'd127, 8'd9, 8'd25, 8'd41, 8'd70);
      8'h53: g = cols(8'd70, 8'd73, 8'd73, 8'd73, 8'd49);
      8'h54: g = cols(8'd1, 8'd1, 8'd127, 8'd1, 8'd1);
      8'h55: g = cols(8'd63, 8'd64, 8'd64, 8'd64, 8'd63);
      8'h56: g = cols(8'd31, 8'd32, 8'd64, 8'd32, 8'd31);
      8'h57: g = cols(8'd63, 8'd64, 8'd56, 8'd64, 8'd63);
      8'h58: g = cols(8'd99, 8'd20, 8'd8, 8'd20, 8'd99);
      8'h59: g = cols(8'd7, 8'd8, 8'd112, 8'd8, 8'd7);
      8'h5a: g = cols(8'd97, 8'd81, 8'd73, 8'd69, 8'd67);
      8'h25: g = cols(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
      default: has_g = 1'b0;
    endcase
    case (gx)
      3'd0: col = g[7:0];
      3'd1: col = g[15:8];
      3'd2: col = g[23:16];
      3'd3: col = g[31:24];
      3'd4: col = g[39:32];
      default: col = '0;
    endcase
    if (has_g) begin
      dot = col[gy];
    end else if (ch == 8'h2d) begin
      dot = (gy == 3'd3);
    end else if (ch == 8'h2e) begin
      dot = (gx == 3'd2) && (gy == 3'd6);
    end
    return dot;
  endfunction

endpackage

// ===== sv/tovl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module tovl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/text_overlay_char_generator.sv =====
// ----------------------------------------------------------------------------
// Text overlay character generator
// Dims the top rows of an ARGB stream and draws one line of 5x7 text on it.
// ----------------------------------------------------------------------------
// Pipeline: a pixel transfer gives its result through the line store read and
// then the result register. Throughput: one item per cycle while the output
// is not stalled; clear and append items act at their transfer and give no
// result. A stall on the output holds both stages. Reset: overlay off, 256 x
// 224 frame, empty open line; the line store itself is not cleared.
module text_overlay_char_generator
  import tovl_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic [31:0] in_pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int AW = $clog2(LINE_CHARS);
  localparam int LW = $clog2(LINE_CHARS + 1);
  localparam logic [12:0] LINE_MAX = 13'(LINE_CHARS);

  // Configuration
  logic        enable_r;
  logic [11:0] width_r;
  logic [11:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE: enable_r <= cfg_data[0];
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_xfer;
  logic is_pixel;
  logic is_append;

  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_xfer   = in_valid && in_ready;
  assign is_pixel  = (cmd_t'(in_cmd) == CMD_PIXEL);
  assign is_append = (cmd_t'(in_cmd) == CMD_APPEND);

  // Line state
  logic [LW-1:0] len_r;
  logic          closed_r;
  logic          wr_en;

  assign wr_en = in_xfer && is_append && !closed_r && (in_char_code != 8'd0)
                 && ({{(13 - LW){1'b0}}, len_r} < LINE_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      closed_r <= 1'b0;
    end else if (in_xfer) begin
      case (cmd_t'(in_cmd))
        CMD_CLEAR: begin
          len_r    <= '0;
          closed_r <= 1'b0;
        end
        CMD_APPEND: begin
          if (!closed_r && in_char_code == 8'd0) begin
            closed_r <= 1'b1;
          end
          if (wr_en) begin
            len_r <= len_r + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Cell index by reciprocal multiply
  logic [11:0] cx;
  logic [27:0] prod;
  logic [9:0]  cell_n;
  logic [11:0] cell_base;
  logic [11:0] cell_off;
  logic        cell_ok;
  logic [AW-1:0] rd_addr;

  assign cx        = in_pixel_x - 12'(CELL_ORIGIN);
  assign prod      = 28'(cx) * 28'(CELL_RECIP);
  assign cell_n    = prod[CELL_SHIFT +: 10];
  assign cell_base = 12'(cell_n) * 12'(CELL_PITCH);
  assign cell_off  = cx - cell_base;
  assign cell_ok   = (13'(cell_n) < {{(13 - LW){1'b0}}, len_r}) && (13'(cell_n) < LINE_MAX);
  assign rd_addr   = cell_n[AW-1:0];

  logic [7:0] rd_char;

  tovl_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CHARS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (len_r[AW-1:0]),
    .wr_data (in_char_code),
    .rd_en   (in_xfer && is_pixel),
    .rd_addr (rd_addr),
    .rd_data (rd_char)
  );

  // Stage 1 registers
  logic [31:0] pix_r;
  logic [11:0] x_r;
  logic [11:0] y_r;
  logic [11:0] base_r;
  logic [2:0]  gx_r;
  logic        cell_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_xfer && is_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && is_pixel) begin
      pix_r     <= in_pixel_in;
      x_r       <= in_pixel_x;
      y_r       <= in_pixel_y;
      base_r    <= cell_base;
      gx_r      <= cell_off[2:0];
      cell_ok_r <= cell_ok;
    end
  end

  // Shade and draw
  logic        active;
  logic        in_glyph;
  logic        dot;
  logic [31:0] dimmed;
  logic [31:0] shade_nxt;
  logic [2:0]  gy;

  assign active = enable_r && (width_r != 12'd0) && (height_r >= 12'(DIM_ROWS))
                  && (y_r < 12'(DIM_ROWS)) && (x_r < width_r);
  assign dimmed = (pix_r & ALPHA_MASK) | ((pix_r & DIM_MASK) >> 2);
  assign gy     = 3'(y_r - 12'(GLYPH_TOP));
  assign in_glyph = (y_r >= 12'(GLYPH_TOP)) && (y_r <= 12'(GLYPH_BOT))
                    && (x_r >= 12'(CELL_ORIGIN)) && (gx_r < 3'd5) && cell_ok_r
                    && ((13'(base_r) + 13'd7) < 13'(width_r));
  assign dot    = dot_on(rd_char, gx_r, gy);

  always_comb begin
    shade_nxt = pix_r;
    if (active) begin
      shade_nxt = (in_glyph && dot) ? INK_WHITE : dimmed;
    end
  end

  // Result register
  logic [31:0] out_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_pixel_r <= shade_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

endmodule

// ===== bench/tb_text_overlay_char_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text overlay character generator testbench
// Streams clear, append and pixel transfers with random gaps on both sides,
// predicts each output pixel from a local line store and 5x7 font, and checks
// the results in order across several frame and enable settings.
// ----------------------------------------------------------------------------
module tb_text_overlay_char_generator;
  import tovl_pkg::*;

  localparam int LINE_DEPTH = LINE_CHARS_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_OFF = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 85;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] pix;
  } overlay_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = CMD_CLEAR;
  logic [7:0]  in_char_code = '0;
  logic [11:0] in_pixel_x = '0;
  logic [11:0] in_pixel_y = '0;
  logic [31:0] in_pixel_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pixel_out;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_ENABLE;
  logic [11:0] cfg_data = '0;

  // Local copy of the block state and registers
  logic [7:0]  text_buf [0:LINE_DEPTH-1];
  int          text_len = 0;
  logic        text_closed = 1'b0;
  logic        ovl_en = 1'b0;
  logic [11:0] ovl_width = WIDTH_RST;
  logic [11:0] ovl_height = HEIGHT_RST;

  overlay_item_t pending_items[$];
  overlay_item_t next_item;
  logic [31:0]   expected_pixels[$];
  logic [31:0]   want_pixel;
  int            items_queued = 0;
  int            fail_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            stall_left = 0;
  logic          stall_kick = 1'b0;
  logic          stall_seen = 1'b0;

  text_overlay_char_generator u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_char_code (in_char_code),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_out(out_pixel_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Five columns per glyph, column 0 in the top byte, bit 0 is the top row
  function automatic logic [39:0] font_columns(input int idx);
    case (idx)
      0:  return {8'd62, 8'd81, 8'd73, 8'd69, 8'd62};
      1:  return {8'd0, 8'd66, 8'd127, 8'd64, 8'd0};
      2:  return {8'd66, 8'd97, 8'd81, 8'd73, 8'd70};
      3:  return {8'd33, 8'd65, 8'd69, 8'd75, 8'd49};
      4:  return {8'd24, 8'd20, 8'd18, 8'd127, 8'd16};
      5:  return {8'd39, 8'd69, 8'd69, 8'd69, 8'd57};
      6:  return {8'd60, 8'd74, 8'd73, 8'd73, 8'd48};
      7:  return {8'd1, 8'd113, 8'd9, 8'd5, 8'd3};
      8:  return {8'd54, 8'd73, 8'd73, 8'd73, 8'd54};
      9:  return {8'd6, 8'd73, 8'd73, 8'd41, 8'd30};
      10: return {8'd126, 8'd17, 8'd17, 8'd17, 8'd126};
      11: return {8'd127, 8'd73, 8'd73, 8'd73, 8'd54};
      12: return {8'd62, 8'd65, 8'd65, 8'd65, 8'd34};
      13: return {8'd127, 8'd65, 8'd65, 8'd34, 8'd28};
      14: return {8'd127, 8'd73, 8'd73, 8'd73, 8'd65};
      15: return {8'd127, 8'd9, 8'd9, 8'd9, 8'd1};
      16: return {8'd62, 8'd65, 8'd73, 8'd73, 8'd122};
      17: return {8'd127, 8'd8, 8'd8, 8'd8, 8'd127};
      18: return {8'd0, 8'd65, 8'd127, 8'd65, 8'd0};
      19: return {8'd32, 8'd64, 8'd65, 8'd63, 8'd1};
      20: return {8'd127, 8'd8, 8'd20, 8'd34, 8'd65};
      21: return {8'd127, 8'd64, 8'd64, 8'd64, 8'd64};
      22: return {8'd127, 8'd2, 8'd12, 8'd2, 8'd127};
      23: return {8'd127, 8'd4, 8'd8, 8'd16, 8'd127};
      24: return {8'd62, 8'd65, 8'd65, 8'd65, 8'd62};
      25: return {8'd127, 8'd9, 8'd9, 8'd9, 8'd6};
      26: return {8'd62, 8'd65, 8'd81, 8'd33, 8'd94};
      27: return {8'd127, 8'd9, 8'd25, 8'd41, 8'd70};
      28: return {8'd70, 8'd73, 8'd73, 8'd73, 8'd49};
      29: return {8'd1, 8'd1, 8'd127, 8'd1, 8'd1};
      30: return {8'd63, 8'd64, 8'd64, 8'd64, 8'd63};
      31: return {8'd31, 8'd32, 8'd64, 8'd32, 8'd31};
      32: return {8'd63, 8'd64, 8'd56, 8'd64, 8'd63};
      33: return {8'd99, 8'd20, 8'd8, 8'd20, 8'd99};
      34: return {8'd7, 8'd8, 8'd112, 8'd8, 8'd7};
      35: return {8'd97, 8'd81, 8'd73, 8'd69, 8'd67};
      default: return '0;
    endcase
  endfunction

  function automatic logic font_dot(input logic [7:0] ch, input int gx, input int gy);
    logic [39:0] glyph;
    logic [7:0]  column;
    if (ch >= "0" && ch <= "9") glyph = font_columns(int'(ch) - int'("0"));
    else if (ch >= "A" && ch <= "Z") glyph = font_columns(10 + int'(ch) - int'("A"));
    else if (ch == "%") glyph = {8'h23, 8'h13, 8'h08, 8'h64, 8'h62};
    else if (ch == "-") return gy == 3;
    else if (ch == ".") return gx == 2 && gy == 6;
    else return 1'b0;
    column = glyph[8 * (4 - gx) +: 8];
    return column[gy];
  endfunction

  function automatic logic [31:0] overlay_pixel(input logic [11:0] x, input logic [11:0] y,
                                                input logic [31:0] p);
    logic [31:0] q;
    int          cx;
    int          cell_no;
    int          gx;
    if (!ovl_en || ovl_width == 0 || ovl_height < DIM_ROWS) return p;
    if (y >= DIM_ROWS || x >= ovl_width) return p;
    q = (p & ALPHA_MASK) | ((p & DIM_MASK) >> 2);
    if (y < GLYPH_TOP || y > GLYPH_BOT || x < CELL_ORIGIN) return q;
    cx = int'(x) - CELL_ORIGIN;
    cell_no = cx / CELL_PITCH;
    gx = cx % CELL_PITCH;
    // the column between glyphs keeps its dimmed value
    if (gx >= 5 || cell_no >= text_len || cell_no >= LINE_DEPTH) return q;
    if (cell_no * CELL_PITCH + 7 >= int'(ovl_width)) return q;
    if (font_dot(text_buf[cell_no], gx, int'(y) - GLYPH_TOP)) q = INK_WHITE;
    return q;
  endfunction

  // Update the line state for one accepted transfer, queue its pixel if any
  task automatic apply_item(input logic [1:0] cmd, input logic [7:0] ch,
                            input logic [11:0] x, input logic [11:0] y,
                            input logic [31:0] p);
    case (cmd)
      CMD_CLEAR: begin
        text_len = 0;
        text_closed = 1'b0;
      end
      CMD_APPEND: begin
        if (!text_closed) begin
          if (ch == 8'h00) begin
            text_closed = 1'b1;
          end else if (text_len < LINE_DEPTH) begin
            text_buf[text_len] = ch;
            text_len++;
          end
        end
      end
      CMD_PIXEL: expected_pixels.insert(expected_pixels.size(), overlay_pixel(x, y, p));
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s: got %08h, expected %08h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Driver: offer the next pending item, with random gaps, when the slot is free
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_item(in_cmd, in_char_code, in_pixel_x, in_pixel_y, in_pixel_in);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending_items[0];
          pending_items.delete(0);
          in_valid <= 1'b1;
          in_cmd <= next_item.cmd;
          in_char_code <= next_item.ch;
          in_pixel_x <= next_item.x;
          in_pixel_y <= next_item.y;
          in_pixel_in <= next_item.pix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      stall_seen <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected pixel_out", out_pixel_out, '0);
        end else begin
          want_pixel = expected_pixels[0];
          expected_pixels.delete(0);
          if (out_pixel_out !== want_pixel) begin
            report_mismatch("pixel_out", out_pixel_out, want_pixel);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (stall_kick != stall_seen) begin
        // long hold-off so the pipeline backs up onto the input
        stall_seen <= stall_kick;
        stall_left <= HOLD_OFF;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_text_overlay_char_generator: FAIL");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] ch,
                            input logic [11:0] x, input logic [11:0] y);
    overlay_item_t item;
    item.cmd = cmd;
    item.ch = ch;
    item.x = x;
    item.y = y;
    item.pix = $urandom;
    pending_items.insert(pending_items.size(), item);
    items_queued++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [11:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE: ovl_en = value[0];
      CFG_WIDTH:  ovl_width = value;
      CFG_HEIGHT: ovl_height = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic en, input logic [11:0] w, input logic [11:0] h);
    write_reg(CFG_ENABLE, {11'd0, en});
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Hold until every item is sent and every pixel is back, then let appends settle
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'("0" + $urandom_range(0, 9));
    if (r < 55) return 8'("A" + $urandom_range(0, 25));
    if (r < 62) return "%";
    if (r < 70) return "-";
    if (r < 78) return ".";
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [11:0] pick_column(input int text_span);
    int r;
    int x;
    r = $urandom_range(0, 99);
    if (r < 65) return 12'($urandom_range(0, text_span));
    if (r < 80) return 12'($urandom);
    x = int'(ovl_width) + $urandom_range(0, 5) - 3;
    if (x < 0) x = 0;
    if (x > 4095) x = 4095;
    return 12'(x);
  endfunction

  function automatic logic [11:0] pick_row(input int near_pct);
    if ($urandom_range(0, 99) < near_pct) return 12'($urandom_range(0, 11));
    return 12'($urandom);
  endfunction

  // Clear, fill, optionally close, then scan pixels over the text rows
  task automatic queue_text_line(input bit long_line);
    int len;
    int span;
    len = long_line ? $urandom_range(LINE_DEPTH - 3, LINE_DEPTH + 6) : $urandom_range(0, 24);
    queue_item(CMD_CLEAR, 8'($urandom), 12'($urandom), 12'($urandom));
    repeat (len) queue_item(CMD_APPEND, pick_char(), 12'($urandom), 12'($urandom));
    if ($urandom_range(0, 9) < 7) begin
      queue_item(CMD_APPEND, 8'h00, 12'($urandom), 12'($urandom));
      repeat ($urandom_range(0, 2)) begin
        queue_item(CMD_APPEND, pick_char(), 12'($urandom), 12'($urandom));
      end
    end
    span = (len + 2) * CELL_PITCH + CELL_ORIGIN;
    if (span > 4095) span = 4095;
    repeat ($urandom_range(15, 40)) begin
      queue_item(CMD_PIXEL, 8'($urandom), pick_column(span), pick_row(80));
    end
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 8)) begin
      queue_item(2'($urandom_range(0, 3)), 8'($urandom), 12'($urandom), pick_row(60));
    end
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    set_config(1'b1, 12'd256, 12'd224);
    set_idle(34, 69);

    // Directed: empty line, every glyph class, close, ignored items, edges
    queue_item(CMD_CLEAR, 8'h00, 12'd0, 12'd0);
    queue_item(CMD_PIXEL, 8'h00, 12'd0, 12'd0);
    queue_item(CMD_APPEND, "A", 12'd0, 12'd0);
    queue_item(CMD_APPEND, "0", 12'd0, 12'd0);
    queue_item(CMD_APPEND, "%", 12'd0, 12'd0);
    queue_item(CMD_APPEND, "-", 12'd0, 12'd0);
    queue_item(CMD_APPEND, ".", 12'd0, 12'd0);
    queue_item(CMD_APPEND, "a", 12'd0, 12'd0);
    queue_item(CMD_APPEND, 8'hff, 12'hfff, 12'hfff);
    queue_item(CMD_APPEND, 8'h00, 12'd0, 12'd0);
    queue_item(CMD_APPEND, "Z", 12'd0, 12'd0);
    queue_item(CMD_UNUSED, 8'hff, 12'hfff, 12'hfff);
    queue_item(CMD_PIXEL, 8'h00, 12'd3, 12'd2);
    queue_item(CMD_PIXEL, 8'h00, 12'd4, 12'd3);
    queue_item(CMD_PIXEL, 8'h00, 12'd10, 12'd4);
    queue_item(CMD_PIXEL, 8'h00, 12'd15, 12'd5);
    queue_item(CMD_PIXEL, 8'h00, 12'd22, 12'd5);
    queue_item(CMD_PIXEL, 8'h00, 12'd29, 12'd8);
    queue_item(CMD_PIXEL, 8'h00, 12'd8, 12'd4);
    queue_item(CMD_PIXEL, 8'h00, 12'd2, 12'd4);
    queue_item(CMD_PIXEL, 8'h00, 12'd5, 12'd9);
    queue_item(CMD_PIXEL, 8'h00, 12'd5, 12'd1);
    queue_item(CMD_PIXEL, 8'h00, 12'd5, 12'd10);
    queue_item(CMD_PIXEL, 8'h00, 12'd300, 12'd3);
    queue_item(CMD_PIXEL, 8'hff, 12'd5, 12'hfff);
    queue_item(CMD_PIXEL, 8'hff, 12'hfff, 12'd0);
    queue_item(CMD_PIXEL, 8'h00, 12'd255, 12'd2);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: set_config(1'b1, 12'd4095, 12'd4095);
        1: set_config(1'b1, 12'd0, 12'd10);
        2: set_config(1'b1, 12'd200, 12'd9);
        3: set_config(1'b1, 12'd8, 12'd10);
        4: set_config(1'b1, 12'd256, 12'd0);
        5: set_config(1'b0, 12'd256, 12'd224);
        6: set_config(1'b1, 12'd7, 12'd100);
        default: begin
          set_config($urandom_range(0, 9) != 0,
                     12'(($urandom_range(0, 9) < 5) ? $urandom_range(8, 300) :
                         ($urandom_range(0, 9) < 6) ? $urandom_range(1, 60) : $urandom),
                     12'(($urandom_range(0, 99) < 85) ? $urandom_range(10, 4095) :
                                                        $urandom_range(0, 12)));
        end
      endcase
      if (phase < 4) set_idle(34, 69);
      else if (phase < 8) set_idle(69, 34);
      else set_idle(0, 0);
      if (phase == 7 || phase == 9) stall_kick <= ~stall_kick;

      target = items_queued + PHASE_ITEMS;
      // at full width every cell fits, so overfill the line once here
      if (phase == 0) queue_text_line(1'b1);
      while (items_queued < target) begin
        if ($urandom_range(0, 99) < 80) queue_text_line($urandom_range(0, 99) < 4);
        else queue_noise();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_text_overlay_char_generator: PASS");
    end else begin
      $display("tb_text_overlay_char_generator: FAIL");
    end
    $finish;
  end

endmodule
